/* design/pwrm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrm_pkg
// shared types, source codes, mode encoding and helpers for the write mux
// ----------------------------------------------------------------------------
package pwrm_pkg;

	localparam int DATA_BITS = 64;
	localparam int ADDR_W    = 64;
	localparam int CNT_W     = 8;
	localparam int SRC_N     = 9;
	localparam int CFG_N     = 4;
	localparam int CFG_IDX_W = $clog2(CFG_N);
	localparam int Q_DEPTH   = 2;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	// source codes
	localparam logic [3:0] SRC_WRDONE   = 4'd0;
	localparam logic [3:0] SRC_HOSTDATA = 4'd1;
	localparam logic [3:0] SRC_RDDEV    = 4'd2;
	localparam logic [3:0] SRC_WRDEV    = 4'd3;
	localparam logic [3:0] SRC_DRAM_A   = 4'd4;
	localparam logic [3:0] SRC_DRAM_B   = 4'd5;
	localparam logic [3:0] SRC_DRAM_C   = 4'd6;
	localparam logic [3:0] SRC_DRAM_D   = 4'd7;
	localparam logic [3:0] SRC_RDDONE   = 4'd8;
	localparam logic [3:0] SRC_NONE     = 4'd9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DRAM_A_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAM_B_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAM_C_OFFSET = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAM_D_OFFSET = 2'd3;

	typedef enum logic [3:0] {
		MODE_IDLE        = 4'd0,
		MODE_HOSTDATA    = 4'd1,
		MODE_RDDONE      = 4'd2,
		MODE_WRDONE      = 4'd3,
		MODE_RDDEV       = 4'd4,
		MODE_WRDEV       = 4'd5,
		MODE_WAIT_RDDONE = 4'd6,
		MODE_DRAM_A      = 4'd7,
		MODE_DRAM_B      = 4'd8,
		MODE_DRAM_C      = 4'd9,
		MODE_DRAM_D      = 4'd10
	} mode_t;

	typedef struct packed {
		logic [SRC_N-1:0]  request_pending;
		logic [SRC_N-1:0]  beat_pending;
		logic [ADDR_W-1:0] head_addr;
		logic [CNT_W-1:0]  head_count;
		logic [63:0]       head_word;
		logic              head_last;
	} in_t;

	typedef struct packed {
		logic [3:0]        request_pop;
		logic [3:0]        beat_pop;
		logic              out_request_valid;
		logic [ADDR_W-1:0] out_addr;
		logic [CNT_W-1:0]  out_count;
		logic              out_beat_valid;
		logic [63:0]       out_word;
		logic              out_last;
	} out_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [3:0]        rpop;
		logic [3:0]        bpop;
		logic              rvalid;
		logic              bvalid;
		logic              dram_add;
		logic [1:0]        dram_sel;
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  count;
		logic [63:0]       word;
		logic              last;
	} cls_t;

	function automatic logic [3:0] data_source(mode_t m);
		logic [3:0] s;
		unique case (m)
			MODE_HOSTDATA: s = SRC_HOSTDATA;
			MODE_RDDONE:   s = SRC_RDDONE;
			MODE_WRDONE:   s = SRC_WRDONE;
			MODE_RDDEV:    s = SRC_RDDEV;
			MODE_WRDEV:    s = SRC_WRDEV;
			MODE_DRAM_A:   s = SRC_DRAM_A;
			MODE_DRAM_B:   s = SRC_DRAM_B;
			MODE_DRAM_C:   s = SRC_DRAM_C;
			MODE_DRAM_D:   s = SRC_DRAM_D;
			default:       s = SRC_NONE;
		endcase
		return s;
	endfunction

	function automatic mode_t dram_mode(logic [1:0] k);
		mode_t m;
		unique case (k)
			2'd0:    m = MODE_DRAM_A;
			2'd1:    m = MODE_DRAM_B;
			2'd2:    m = MODE_DRAM_C;
			default: m = MODE_DRAM_D;
		endcase
		return m;
	endfunction

	function automatic logic [63:0] word_mask();
		return {64{1'b1}} >> (64 - DATA_BITS);
	endfunction

endpackage
`default_nettype wire

/* design/pcie_write_request_mux_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// path: a word accepted at the input is written to the queue, then to the output register
// throughput: one word per cycle while out_ready holds, with the grant and mode update
// done in the front stage; the two-entry queue and output register absorb stalls
// reset: arst_n clears transfer mode to idle, round robin pointer to dram a,
// beat counter and all four dram offsets to zero, and empties the queue
// ----------------------------------------------------------------------------
// pcie_write_request_mux_core
// merges nine write sources onto one request channel and one data channel
// ----------------------------------------------------------------------------
module pcie_write_request_mux_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration: dram address offsets
	input  wire logic                            cfg_we,
	input  wire logic [pwrm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [63:0]                     cfg_data,
	// input word: pending masks and head entries
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire pwrm_pkg::in_t                   in_data,
	// output word: pops and forwarded request and beat
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output pwrm_pkg::out_t                       out_data
);

	// front to queue
	logic              push;
	logic              full;
	pwrm_pkg::cls_t    rec;
	// queue to back
	logic              pop;
	logic              head_valid;
	pwrm_pkg::cls_t    head_data;

	// front: arbitration, mode tracking and beat counting, one word a cycle while the queue is not full
	pwrm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.push     (push),
		.full     (full),
		.rec      (rec)
	);

	// decoupling queue so front and back stall independently
	pwrm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (rec),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// back: offset add, word masking and the output register
	pwrm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

/* design/pwrm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrm_front
// grant arbitration, transfer mode tracking and beat counting per accepted word
// ----------------------------------------------------------------------------
module pwrm_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire pwrm_pkg::in_t  in_data,
	output logic                push,
	input  wire logic           full,
	output pwrm_pkg::cls_t      rec
);

	pwrm_pkg::mode_t                  mode_q, grant_mode, mode_d;
	logic [1:0]                       last_dram_q, grant_dram;
	logic [pwrm_pkg::CNT_W-1:0]       beats_left_q, grant_beats, beats_d, beats_dec;
	logic [3:0]                       grant_src, dsrc;
	logic                             grant_dram_hit;
	logic                             beat_ok;
	logic                             counted;
	logic [15:0]                      beat_ext;
	logic                             in_fire;

	assign in_ready = !full;
	assign in_fire  = in_valid && in_ready;
	assign push     = in_valid;

	// request grant
	always_comb begin
		logic [3:0] dreq;
		logic [1:0] k;
		logic       found;
		dreq           = in_data.request_pending[7:4];
		found          = 1'b0;
		k              = last_dram_q;
		grant_mode     = mode_q;
		grant_src      = pwrm_pkg::SRC_NONE;
		grant_beats    = beats_left_q;
		grant_dram     = last_dram_q;
		grant_dram_hit = 1'b0;
		unique case (mode_q)
			pwrm_pkg::MODE_IDLE: begin
				if (in_data.request_pending[0]) begin
					grant_src  = pwrm_pkg::SRC_WRDONE;
					grant_mode = pwrm_pkg::MODE_WRDONE;
				end else if (in_data.request_pending[1]) begin
					grant_src  = pwrm_pkg::SRC_HOSTDATA;
					grant_mode = pwrm_pkg::MODE_HOSTDATA;
				end else if (in_data.request_pending[2]) begin
					grant_src   = pwrm_pkg::SRC_RDDEV;
					grant_mode  = pwrm_pkg::MODE_RDDEV;
					grant_beats = in_data.head_count;
				end else if (in_data.request_pending[3]) begin
					grant_src   = pwrm_pkg::SRC_WRDEV;
					grant_mode  = pwrm_pkg::MODE_WRDEV;
					grant_beats = in_data.head_count;
				end else begin
					// round robin starting after the last dram served
					for (int i = 1; i <= 4; i++) begin
						k = last_dram_q + 2'(i);
						if (!found && dreq[k]) begin
							found          = 1'b1;
							grant_src      = {2'b01, k};
							grant_mode     = pwrm_pkg::dram_mode(k);
							grant_dram     = k;
							grant_beats    = in_data.head_count;
							grant_dram_hit = 1'b1;
						end
					end
				end
			end
			pwrm_pkg::MODE_WAIT_RDDONE: begin
				if (in_data.request_pending[8]) begin
					grant_src  = pwrm_pkg::SRC_RDDONE;
					grant_mode = pwrm_pkg::MODE_RDDONE;
				end
			end
			default: ;
		endcase
	end

	assign dsrc      = pwrm_pkg::data_source(grant_mode);
	assign beat_ext  = {7'b0, in_data.beat_pending};
	assign beat_ok   = beat_ext[dsrc];
	assign counted   = grant_mode > pwrm_pkg::MODE_WRDONE;
	assign beats_dec = grant_beats - 1'b1;

	// next state
	always_comb begin
		mode_d  = grant_mode;
		beats_d = grant_beats;
		if (beat_ok) begin
			if (!counted) begin
				if (in_data.head_last) begin
					mode_d = (grant_mode == pwrm_pkg::MODE_HOSTDATA) ?
						pwrm_pkg::MODE_WAIT_RDDONE : pwrm_pkg::MODE_IDLE;
				end
			end else begin
				beats_d = beats_dec;
				if (beats_dec == '0) begin
					mode_d = pwrm_pkg::MODE_IDLE;
				end
			end
		end
	end

	// classified word
	always_comb begin
		rec          = '0;
		rec.rpop     = grant_src;
		rec.bpop     = pwrm_pkg::SRC_NONE;
		rec.dram_sel = grant_dram;
		if (grant_src != pwrm_pkg::SRC_NONE) begin
			rec.rvalid   = 1'b1;
			rec.addr     = in_data.head_addr;
			rec.count    = in_data.head_count;
			rec.dram_add = grant_dram_hit;
		end
		if (beat_ok) begin
			rec.bpop   = dsrc;
			rec.bvalid = 1'b1;
			rec.word   = in_data.head_word;
			rec.last   = in_data.head_last || (counted && beats_dec == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= pwrm_pkg::MODE_IDLE;
			last_dram_q  <= 2'd0;
			beats_left_q <= '0;
		end else if (in_fire) begin
			mode_q       <= mode_d;
			last_dram_q  <= grant_dram;
			beats_left_q <= beats_d;
		end
	end

	// requests are only granted from idle or while waiting for read-done
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && rec.rvalid |->
			mode_q == pwrm_pkg::MODE_IDLE || mode_q == pwrm_pkg::MODE_WAIT_RDDONE)
		else $error("request granted mid transfer");

	// after host data only read-done may be granted
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && mode_q == pwrm_pkg::MODE_WAIT_RDDONE |->
			rec.rpop == pwrm_pkg::SRC_NONE || rec.rpop == pwrm_pkg::SRC_RDDONE)
		else $error("wrong grant after host data");

	// counted transfer ending forces last and returns to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && rec.bvalid && counted && grant_beats == 8'd1 |=>
			mode_q == pwrm_pkg::MODE_IDLE)
		else $error("counted transfer did not close");

	// a dram grant moves the round robin pointer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && rec.dram_add |=> last_dram_q == $past(rec.rpop[1:0]))
		else $error("round robin pointer not updated");

endmodule
`default_nettype wire

/* design/pwrm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrm_queue
// short fifo between classification and output
// ----------------------------------------------------------------------------
module pwrm_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire pwrm_pkg::cls_t  push_data,
	output logic                 full,
	input  wire logic            pop,
	output logic                 head_valid,
	output pwrm_pkg::cls_t       head_data
);

	pwrm_pkg::cls_t                 mem_q [pwrm_pkg::Q_DEPTH];
	logic [pwrm_pkg::Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [pwrm_pkg::Q_CNT_W-1:0]   cnt_q;
	logic                           do_push, do_pop;

	function automatic logic [pwrm_pkg::Q_CNT_W-1:0] Q_CNT_W_ONE(logic b);
		return {{(pwrm_pkg::Q_CNT_W-1){1'b0}}, b};
	endfunction

	assign full       = cnt_q == pwrm_pkg::Q_CNT_W'(pwrm_pkg::Q_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + Q_CNT_W_ONE(do_push) - Q_CNT_W_ONE(do_pop);
		end
	end

endmodule
`default_nettype wire

/* design/pwrm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrm_back
// offset registers, dram offset add and the registered output stage
// ----------------------------------------------------------------------------
module pwrm_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [pwrm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [63:0]                       cfg_data,
	input  wire logic                              head_valid,
	input  wire pwrm_pkg::cls_t                    head_data,
	output logic                                   pop,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output pwrm_pkg::out_t                         out_data
);

	logic [63:0]          offset_q [pwrm_pkg::CFG_N];
	logic [63:0]          sel_offset;
	logic                 out_valid_q;
	pwrm_pkg::out_t       out_data_q, out_d;

	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign sel_offset = head_data.dram_add ? offset_q[head_data.dram_sel] : 64'd0;

	always_comb begin
		out_d                   = '0;
		out_d.request_pop       = head_data.rpop;
		out_d.beat_pop          = head_data.bpop;
		out_d.out_request_valid = head_data.rvalid;
		out_d.out_addr          = head_data.addr + sel_offset;
		out_d.out_count         = head_data.count;
		out_d.out_beat_valid    = head_data.bvalid;
		out_d.out_word          = head_data.word & pwrm_pkg::word_mask();
		out_d.out_last          = head_data.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pwrm_pkg::CFG_N; i++) begin
				offset_q[i] <= 64'd0;
			end
		end else if (cfg_we) begin
			offset_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= out_d;
		end
	end

endmodule
`default_nettype wire
